[sv/orb_pkg.sv]
// Shared types and constants for the overwriting ring buffer.
// No dependencies; imported by the controller, the datapath and the top level.
package orb_pkg;

    // Default geometry of the slot store
    localparam int DEPTH_LOG2_DEF = 8;
    localparam int ELEM_WIDTH_DEF = 32;

    // Log2 of the capacity selected after reset, clamped to the store depth
    localparam int CAP_RESET = 8;

    // Fixed port widths
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    // Request codes
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } act_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture request, launch slot read
        logic exec;       // execute captured request, register result
        logic wr_mem;     // write captured element at write index
        logic adv_rd;     // advance read index
        logic adv_wr;     // advance write index
        logic clear;      // return both indices to zero
        logic rd_valid;   // result carries the oldest element
        logic underflow;  // pop or peek on an empty buffer
        logic overwrote;  // push discarded the oldest element
    } orb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
    } orb_stat_t;

endpackage

[sv/orb_ctrl.sv]
// Controller for the overwriting ring buffer: request capture and decode.
// Depends on orb_pkg for the request codes and the command and status structs.
module orb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  orb_pkg::orb_stat_t stat,
    output orb_pkg::orb_cmd_t  cmd,
    output logic               busy,
    output logic               cfg_ready,
    output logic               done
);
    import orb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    act_t   act_reg;
    logic   done_reg;
    logic   accept;

    assign busy      = (state_reg == ST_EXEC);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign accept    = start && (state_reg == ST_IDLE);

    // Advance the state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decode the captured request against the buffer status
    always_comb
    begin
        cmd      = '0;
        cmd.load = accept;
        if (state_reg == ST_EXEC)
        begin
            cmd.exec = 1'b1;
            unique case (act_reg)
                ACT_PUSH:
                begin
                    cmd.wr_mem    = 1'b1;
                    cmd.adv_wr    = 1'b1;
                    cmd.adv_rd    = stat.full;
                    cmd.overwrote = stat.full;
                end
                ACT_POP:
                begin
                    cmd.underflow = stat.empty;
                    cmd.rd_valid  = !stat.empty;
                    cmd.adv_rd    = !stat.empty;
                end
                ACT_PEEK:
                begin
                    cmd.underflow = stat.empty;
                    cmd.rd_valid  = !stat.empty;
                end
                ACT_CLEAR:
                begin
                    cmd.clear = 1'b1;
                end
                default:
                begin
                    cmd.clear = 1'b0;
                end
            endcase
        end
    end

    // Hold state, strobe the result in the cycle after execution
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    // Capture the request code
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= act_t'(action);
        end
    end

endmodule

[sv/orb_datapath.sv]
// Datapath for the overwriting ring buffer: slot memory, wrap-bit indices,
// capacity register and result registers. Depends on orb_pkg.
module orb_datapath
#(
    parameter int DEPTH_LOG2 = orb_pkg::DEPTH_LOG2_DEF,
    parameter int ELEM_WIDTH = orb_pkg::ELEM_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  orb_pkg::orb_cmd_t           cmd,
    output orb_pkg::orb_stat_t          stat,
    input  logic [orb_pkg::DATA_W-1:0]  push_data,
    input  logic                        cfg_we,
    input  logic [orb_pkg::CFG_W-1:0]   cfg_data,
    output logic [orb_pkg::DATA_W-1:0]  read_data,
    output logic                        read_valid,
    output logic                        underflow,
    output logic                        overwrote,
    output logic                        is_empty,
    output logic                        is_full,
    output logic [DEPTH_LOG2:0]         fill_count
);
    import orb_pkg::*;

    localparam int IW    = DEPTH_LOG2 + 1;
    localparam int CAP_W = $clog2(DEPTH_LOG2 + 1);
    localparam int SLOTS = 1 << DEPTH_LOG2;
    localparam int CAP_R = (CAP_RESET > DEPTH_LOG2) ? DEPTH_LOG2 : CAP_RESET;
    localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(DEPTH_LOG2);
    localparam logic [CAP_W-1:0] CAP_INIT = CAP_W'(CAP_R);
    localparam logic [CFG_W:0]   CFG_MAX  = (CFG_W+1)'(DEPTH_LOG2);

    logic [ELEM_WIDTH-1:0] mem [SLOTS];

    logic [CAP_W-1:0]      cap_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic [IW-1:0]         rd_idx_next;
    logic [IW-1:0]         wr_idx_reg;
    logic [IW-1:0]         wr_idx_next;
    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] rd_q_reg;

    logic [CAP_W-1:0]      shamt;
    logic [IW-1:0]         wrap_mask;
    logic [IW-1:0]         cap_bit;
    logic [DEPTH_LOG2-1:0] slot_mask;
    logic [DEPTH_LOG2-1:0] wr_addr;
    logic [DEPTH_LOG2-1:0] rd_addr;
    logic [IW-1:0]         count_next;

    logic [DATA_W-1:0]     read_data_reg;
    logic                  read_valid_reg;
    logic                  underflow_reg;
    logic                  overwrote_reg;
    logic                  is_empty_reg;
    logic                  is_full_reg;
    logic [IW-1:0]         fill_count_reg;

    // Masks for the configured capacity
    assign shamt     = CAP_MAX - cap_reg;
    assign wrap_mask = {IW{1'b1}} >> shamt;
    assign cap_bit   = IW'(1) << cap_reg;
    assign slot_mask = {DEPTH_LOG2{1'b1}} >> shamt;
    assign wr_addr   = wr_idx_reg[DEPTH_LOG2-1:0] & slot_mask;
    assign rd_addr   = rd_idx_reg[DEPTH_LOG2-1:0] & slot_mask;

    // Report occupancy before the request
    assign stat.empty = (rd_idx_reg == wr_idx_reg);
    assign stat.full  = (wr_idx_reg == (rd_idx_reg ^ cap_bit));

    // Advance or clear the indices
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        if (cmd.clear)
        begin
            rd_idx_next = '0;
            wr_idx_next = '0;
        end
        else
        begin
            if (cmd.adv_rd)
            begin
                rd_idx_next = (rd_idx_reg + IW'(1)) & wrap_mask;
            end
            if (cmd.adv_wr)
            begin
                wr_idx_next = (wr_idx_reg + IW'(1)) & wrap_mask;
            end
        end
        count_next = (wr_idx_next - rd_idx_next) & wrap_mask;
    end

    // Hold capacity and indices; a capacity write restarts the buffer empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_INIT;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg    <= ({1'b0, cfg_data} > CFG_MAX) ? CAP_MAX : CAP_W'(cfg_data);
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end
        else if (cmd.exec)
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    // Slot memory: write on push, read the oldest slot on request capture
    always_ff @(posedge clk)
    begin
        if (cmd.wr_mem)
        begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.load)
        begin
            rd_q_reg <= mem[rd_addr];
            data_reg <= ELEM_WIDTH'(push_data);
        end
    end

    // Register the result of the executed request
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            read_data_reg  <= cmd.rd_valid ? DATA_W'(rd_q_reg) : '0;
            read_valid_reg <= cmd.rd_valid;
            underflow_reg  <= cmd.underflow;
            overwrote_reg  <= cmd.overwrote;
            is_empty_reg   <= (rd_idx_next == wr_idx_next);
            is_full_reg    <= (wr_idx_next == (rd_idx_next ^ cap_bit));
            fill_count_reg <= count_next;
        end
    end

    assign read_data  = read_data_reg;
    assign read_valid = read_valid_reg;
    assign underflow  = underflow_reg;
    assign overwrote  = overwrote_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;
    assign fill_count = fill_count_reg;

endmodule

[sv/overwriting_ring_buffer_unit.sv]
// Top level of the overwriting ring buffer: controller plus datapath.
// Depends on orb_pkg, orb_ctrl and orb_datapath.
//
// Usage:
//   Request channel: drive action and push_data with start high; the request
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with read_data,
//   read_valid, underflow, overwrote, is_empty, is_full and fill_count.
//   The receiver cannot stall; it must take the result in that cycle.
//   Config channel: cfg_data (log2 of capacity, clamped to DEPTH_LOG2) is
//   written when cfg_valid and cfg_ready are both high; cfg_ready is high
//   while no request is executing. A write empties the buffer.
//   Timing: the accepting edge moves the controller to its execute state,
//   and the edge that ends that state raises done with the registered result.
//   Sequence: no request is accepted while busy. The slot memory read is
//   registered, so the capture cycle launches the read and the following
//   cycle updates the indices and writes the result registers. A new
//   request may be accepted in the cycle that done is shown.
//   Reset: indices go to zero and the capacity to its default; slot contents
//   are not cleared and are never returned as read_data before being written.
module overwriting_ring_buffer_unit
#(
    parameter int DEPTH_LOG2 = orb_pkg::DEPTH_LOG2_DEF,
    parameter int ELEM_WIDTH = orb_pkg::ELEM_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [orb_pkg::DATA_W-1:0]  push_data,
    output logic                        done,
    output logic [orb_pkg::DATA_W-1:0]  read_data,
    output logic                        read_valid,
    output logic                        underflow,
    output logic                        overwrote,
    output logic                        is_empty,
    output logic                        is_full,
    output logic [DEPTH_LOG2:0]         fill_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [orb_pkg::CFG_W-1:0]   cfg_data
);
    import orb_pkg::*;

    orb_cmd_t  cmd;
    orb_stat_t stat;
    logic      cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    // Sequence requests
    orb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done)
    );

    // Store elements and track indices
    orb_datapath
    #(
        .DEPTH_LOG2 (DEPTH_LOG2),
        .ELEM_WIDTH (ELEM_WIDTH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .push_data  (push_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .read_data  (read_data),
        .read_valid (read_valid),
        .underflow  (underflow),
        .overwrote  (overwrote),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .fill_count (fill_count)
    );

endmodule

[sv/orb_checker.sv]
// Port-level checks for the overwriting ring buffer, bound to the top level.
// Depends on orb_pkg and overwriting_ring_buffer_unit.
module orb_checker
#(
    parameter int DEPTH_LOG2 = orb_pkg::DEPTH_LOG2_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                read_valid,
    input logic                underflow,
    input logic                overwrote,
    input logic                is_empty,
    input logic                is_full,
    input logic [DEPTH_LOG2:0] fill_count
);
    import orb_pkg::*;

    // An accepted request occupies the block for exactly one execute cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by a result");

    // Result flags agree with each other
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!(is_empty && is_full) && !(read_valid && underflow)))
        else $error("contradictory result flags");

    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overwrote) |-> (is_full && !is_empty))
        else $error("overwrite left buffer not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (fill_count == '0)))
        else $error("empty flag disagrees with fill count");

endmodule

bind overwriting_ring_buffer_unit orb_checker
#(
    .DEPTH_LOG2 (DEPTH_LOG2)
)
u_orb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_valid (read_valid),
    .underflow  (underflow),
    .overwrote  (overwrote),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .fill_count (fill_count)
);
